@@ rtl/mqpp_pkg.sv @@
// Shared types, codes and helper function of the MQTT packet byte parser
package mqpp_pkg;

  // control packet types with a structured body
  localparam logic [3:0] TYPE_CONNECT = 4'd1;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_PUBREL  = 4'd6;

  // fixed CONNECT variable header length
  localparam int CON_HDR_BYTES = 10;

  // position limits inside the body
  localparam logic [16:0] PUB_FRONT_NO_ID = 17'd2;
  localparam logic [16:0] PUB_FRONT_ID    = 17'd4;
  localparam logic [16:0] CON_FRONT       = 17'(CON_HDR_BYTES + 2);
  localparam logic [27:0] MIN_ID_BODY     = 28'd2;

  // widths of the result transaction
  localparam int OUT_BITS  = 103;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  typedef enum logic [2:0] {
    PH_EMPTY,
    PH_LENGTH,
    PH_BODY,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_HEADER     = 4'd0,
    ROLE_LENGTH     = 4'd1,
    ROLE_NAME_LEN   = 4'd2,
    ROLE_NAME       = 4'd3,
    ROLE_MSG_ID     = 4'd4,
    ROLE_CONNECT_HDR = 4'd5,
    ROLE_PAYLOAD    = 4'd6,
    ROLE_BODY       = 4'd7,
    ROLE_IGNORED    = 4'd8
  } role_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // one result transaction
  typedef struct packed {
    logic [27:0] payload_length;
    logic [15:0] name_length;
    logic [15:0] message_id;
    logic [27:0] remaining_length;
    logic        retain_flag;
    logic [1:0]  qos_level;
    logic        dup_flag;
    logic [3:0]  packet_type;
    status_t     parse_status;
    role_t       byte_role;
    logic        byte_consumed;
  } result_t;

  // fit check of the variable header against the body
  typedef struct packed {
    logic        ok;
    logic        has_payload;
    logic [16:0] need;
  } fit_t;

  function automatic fit_t front_fit(logic [3:0] ptype, logic [1:0] qos,
                                     logic [27:0] blen, logic [15:0] nlen);
    fit_t f;
    f.ok          = 1'b1;
    f.has_payload = 1'b0;
    f.need        = '0;
    if (ptype == TYPE_PUBLISH) begin
      f.need        = 17'(nlen) + ((qos != 2'd0) ? PUB_FRONT_ID : PUB_FRONT_NO_ID);
      f.ok          = 28'(f.need) <= blen;
      f.has_payload = 1'b1;
    end else if (ptype == TYPE_CONNECT) begin
      f.need        = 17'(nlen) + CON_FRONT;
      f.ok          = 28'(f.need) <= blen;
      f.has_payload = 1'b1;
    end else if (ptype == TYPE_PUBREL) begin
      f.ok = blen >= MIN_ID_BODY;
    end
    return f;
  endfunction

endpackage

@@ rtl/mqpp_state.sv @@
// Parser state registers, byte role decode and result assembly
module mqpp_state #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             action,
  input  logic [7:0]       data_byte,
  output mqpp_pkg::result_t result
);
  import mqpp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [2:0]  lcnt_r, lcnt_nxt;
  logic [27:0] blen_r, blen_nxt;
  logic [27:0] bpos_r, bpos_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [15:0] mid_r, mid_nxt;

  logic        consumed;
  role_t       role;
  logic [3:0]  ptype;
  logic [1:0]  qos;
  logic [28:0] name_end;
  logic [27:0] len_group;
  logic [27:0] bpos_inc;
  logic [15:0] nlen_upd;
  fit_t        body_fit;
  fit_t        fit;
  logic [27:0] payload;

  assign ptype    = hdr_r[7:4];
  assign qos      = hdr_r[2:1];
  assign name_end = 29'(nlen_r);
  assign bpos_inc = bpos_r + 28'd1;

  // role of the byte and whether it is taken
  always_comb begin
    consumed = 1'b0;
    role     = ROLE_IGNORED;
    if (!action) begin
      case (phase_r)
        PH_EMPTY: begin
          consumed = 1'b1;
          role     = ROLE_HEADER;
        end
        PH_LENGTH: begin
          consumed = 1'b1;
          role     = ROLE_LENGTH;
        end
        PH_BODY: begin
          consumed = 1'b1;
          if (ptype == TYPE_PUBLISH) begin
            if (bpos_r < 28'd2) begin
              role = ROLE_NAME_LEN;
            end else if (29'(bpos_r) < name_end + 29'd2) begin
              role = ROLE_NAME;
            end else if (qos != 2'd0 && 29'(bpos_r) < name_end + 29'd4) begin
              role = ROLE_MSG_ID;
            end else begin
              role = ROLE_PAYLOAD;
            end
          end else if (ptype == TYPE_CONNECT) begin
            if (bpos_r < 28'(CON_HDR_BYTES)) begin
              role = ROLE_CONNECT_HDR;
            end else if (bpos_r < 28'(CON_HDR_BYTES + 2)) begin
              role = ROLE_NAME_LEN;
            end else if (29'(bpos_r) < name_end + 29'(CON_HDR_BYTES + 2)) begin
              role = ROLE_NAME;
            end else begin
              role = ROLE_PAYLOAD;
            end
          end else if (ptype == TYPE_PUBREL && bpos_r < 28'd2) begin
            role = ROLE_MSG_ID;
          end else begin
            role = ROLE_BODY;
          end
        end
        default: begin
          consumed = 1'b0;
          role     = ROLE_IGNORED;
        end
      endcase
    end
  end

  // base-128 group placed by the length byte count
  always_comb begin
    case (lcnt_r[1:0])
      2'd0:    len_group = {21'd0, data_byte[6:0]};
      2'd1:    len_group = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    len_group = {7'd0, data_byte[6:0], 14'd0};
      default: len_group = {data_byte[6:0], 21'd0};
    endcase
  end

  // name length with this body byte shifted in, and the fit on it
  assign nlen_upd = (role == ROLE_NAME_LEN) ? {nlen_r[7:0], data_byte} : nlen_r;
  assign body_fit = front_fit(ptype, qos, blen_r, nlen_upd);

  // next phase and captured fields
  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    lcnt_nxt  = lcnt_r;
    blen_nxt  = blen_r;
    bpos_nxt  = bpos_r;
    nlen_nxt  = nlen_r;
    mid_nxt   = mid_r;
    if (action) begin
      phase_nxt = PH_EMPTY;
      hdr_nxt   = '0;
      lcnt_nxt  = '0;
      blen_nxt  = '0;
      bpos_nxt  = '0;
      nlen_nxt  = '0;
      mid_nxt   = '0;
    end else begin
      case (phase_r)
        PH_EMPTY: begin
          hdr_nxt   = data_byte;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          blen_nxt = blen_r | len_group;
          lcnt_nxt = lcnt_r + 3'd1;
          if (!data_byte[7]) begin
            bpos_nxt  = '0;
            phase_nxt = (blen_nxt == 28'd0) ? PH_DONE : PH_BODY;
          end else if (lcnt_nxt >= 3'(MAX_LENGTH_BYTES)) begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_BODY: begin
          nlen_nxt = nlen_upd;
          if (role == ROLE_MSG_ID) begin
            mid_nxt = {mid_r[7:0], data_byte};
          end
          bpos_nxt = bpos_inc;
          if (bpos_inc >= blen_r) begin
            phase_nxt = body_fit.ok ? PH_DONE : PH_ERROR;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // fit and payload size on the updated state
  assign fit = front_fit(hdr_nxt[7:4], hdr_nxt[2:1], blen_nxt, nlen_nxt);
  assign payload = (phase_nxt == PH_DONE && fit.has_payload && fit.ok) ?
                   blen_nxt - 28'(fit.need) : '0;

  // result assembly
  always_comb begin
    result.byte_consumed    = consumed;
    result.byte_role        = role;
    result.parse_status     = (phase_nxt == PH_DONE)  ? ST_DONE :
                              (phase_nxt == PH_ERROR) ? ST_ERROR : ST_BUSY;
    result.packet_type      = hdr_nxt[7:4];
    result.dup_flag         = hdr_nxt[3];
    result.qos_level        = hdr_nxt[2:1];
    result.retain_flag      = hdr_nxt[0];
    result.remaining_length = blen_nxt;
    result.message_id       = mid_nxt;
    result.name_length      = nlen_nxt;
    result.payload_length   = payload;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EMPTY;
      hdr_r   <= '0;
      lcnt_r  <= '0;
      blen_r  <= '0;
      bpos_r  <= '0;
      nlen_r  <= '0;
      mid_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      lcnt_r  <= lcnt_nxt;
      blen_r  <= blen_nxt;
      bpos_r  <= bpos_nxt;
      nlen_r  <= nlen_nxt;
      mid_r   <= mid_nxt;
    end
  end

endmodule

@@ rtl/mqpp_out_stage.sv @@
// Result register of the parser with its stream handshake
module mqpp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mqpp_pkg::result_t result,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [8*mqpp_pkg::OUT_BYTES-1:0] out_tdata
);
  import mqpp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // register can take a result when empty or being drained
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(8*OUT_BYTES - OUT_BITS){1'b0}}, data_r};

endmodule

@@ rtl/mqtt_packet_byte_parser.sv @@
// Top level of the MQTT control packet byte parser
//
// The block takes one byte of an MQTT control packet per input transaction
// and returns one result transaction for each. in_tdata carries the byte,
// in_tuser the action: low pushes the byte, high clears the parser so that
// the next byte is taken as a new fixed header. Each result tells whether
// the byte was taken, its role in the packet, the parse status and the
// header fields, lengths and message id decoded so far; the payload length
// shows once the packet is complete.
// A byte passes the input register, then the role decode and state update
// into the result register. One byte is taken every cycle unless the
// receiver stalls; the parser state update is combinational from its
// registers, so bytes follow back to back.
// Reset empties the input and result registers and returns the parser to
// the empty state; in_tready stays low during reset. When the receiver
// stalls, the result register holds and the input register fills, after
// which in_tready drops until a result is taken.
module mqtt_packet_byte_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  // [0] byte_consumed, [4:1] byte_role, [6:5] parse_status, [10:7] packet_type,
  // [11] dup_flag, [13:12] qos_level, [14] retain_flag, [42:15] remaining_length,
  // [58:43] message_id, [74:59] name_length, [102:75] payload_length, [103] zero
  output logic [8*mqpp_pkg::OUT_BYTES-1:0] out_tdata
);
  import mqpp_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_action_r;
  logic [7:0] s1_byte_r;
  logic       out_free;
  logic       advance;
  logic       in_take;
  result_t    result;

  // input register handshake
  assign advance   = s1_valid_r && out_free;
  assign in_tready = rst_n && (!s1_valid_r || out_free);
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_tuser;
      s1_byte_r   <= in_tdata;
    end
  end

  // parser state and decode
  mqpp_state #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .action   (s1_action_r),
    .data_byte(s1_byte_r),
    .result   (result)
  );

  // result register
  mqpp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .free      (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

@@ rtl/mqpp_checker.sv @@
// Port-level checks of the MQTT packet byte parser and their bind
module mqpp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [8*mqpp_pkg::OUT_BYTES-1:0] out_tdata
);
  import mqpp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a taken byte has a result waiting after the input and result registers
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no result after an input transaction");

  // a taken byte has a role, an untaken one is ignored
  a_role_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] != ROLE_IGNORED)))
    else $error("byte role disagrees with consumed flag");

  // payload length only on a complete packet
  a_payload_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[102:75] != 28'd0) |-> out_tdata[6:5] == ST_DONE)
    else $error("payload length outside complete status");

  // a clear shows an empty result
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && out_tdata[6:5] == ST_BUSY
    |-> out_tdata[102:7] == 96'd0)
    else $error("clear result carries stale fields");

endmodule

bind mqtt_packet_byte_parser mqpp_checker u_mqpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
